// ===== src/ssdk_pkg.sv =====
`timescale 1ns / 1ps

package ssdk_pkg;

    // Capacity of one set and the derived index and count widths.
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Field widths.
    localparam int KEY_W   = 32;
    localparam int IDENT_W = 16;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One input word.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [IDENT_W-1:0] ident;
        logic               final_req;
    } item_t;

    // One output word.
    typedef struct packed {
        logic [KEY_W-1:0]   key_out;
        logic [IDENT_W-1:0] ident_out;
        logic               run_end;
        logic               overflow;
    } result_t;

    // A classified word as the front hands it to the back.
    typedef struct packed {
        item_t            item;
        logic             store;
        logic [IDX_W-1:0] slot;
        logic             ovf;
    } job_t;

    // One entry of the sort store.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [IDENT_W-1:0] ident;
    } entry_t;

endpackage

// ===== src/selection_sort_descending_keyed_unit.sv =====
`timescale 1ns / 1ps
// After its final word leaves the queue, a set is sorted by one selection pass per head
// position (scan, wait, two swap writes); each result is then read out by a read state
// and a write state. Throughput: loading takes one word per cycle while the back is in
// its load state; a following set waits in the queue until the current set is read out.
// Reset: asynchronous, active low; clears the queue, the fill count, the drop flag and the
// sequencer. The store contents are not cleared and are only read after being written.

module selection_sort_descending_keyed_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  ssdk_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output ssdk_pkg::result_t result
);
    import ssdk_pkg::*;

    logic push;
    job_t push_job;
    logic q_full;
    logic q_pop;
    job_t q_job;
    logic q_nonempty;

    // Front: accepts words and tags each with its slot or a drop.
    ssdk_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .push_job   (push_job),
        .q_full     (q_full)
    );

    // Queue decoupling the two halves.
    ssdk_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_job),
        .nonempty (q_nonempty)
    );

    // Back: stores, sorts and emits the set.
    ssdk_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_nonempty   (q_nonempty),
        .q_job        (q_job),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== src/ssdk_front.sv =====
`timescale 1ns / 1ps

module ssdk_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  ssdk_pkg::item_t item,
    output logic            push,
    output ssdk_pkg::job_t  push_job,
    input  logic            q_full
);
    import ssdk_pkg::*;

    logic [CNT_W-1:0] fill_count_reg;
    logic [CNT_W-1:0] fill_count_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic             accept;
    logic             store;

    // Input side stalls only while the queue is full.
    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;
    assign push       = accept;

    // Classify the word: a free slot takes it, otherwise it is dropped.
    always_comb
    begin
        store              = (fill_count_reg < CNT_W'(MAX_ENTRIES));
        push_job.item      = item;
        push_job.store     = store;
        push_job.slot      = fill_count_reg[IDX_W-1:0];
        push_job.ovf       = dropped_reg || !store;
        fill_count_next    = fill_count_reg;
        dropped_next       = dropped_reg;
        if (accept)
        begin
            if (item.final_req)
            begin
                fill_count_next = '0;
                dropped_next    = 1'b0;
            end
            else
            begin
                if (store)
                begin
                    fill_count_next = fill_count_reg + CNT_W'(1);
                end
                dropped_next = dropped_reg || !store;
            end
        end
    end

    // Set bookkeeping registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            dropped_reg    <= 1'b0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            dropped_reg    <= dropped_next;
        end
    end

endmodule

// ===== src/ssdk_queue.sv =====
`timescale 1ns / 1ps

module ssdk_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ssdk_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output ssdk_pkg::job_t pop_job,
    output logic           nonempty
);
    import ssdk_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push;
    logic              do_pop;

    // Status and head of the queue.
    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign pop_job  = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

    // Payload slots.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== src/ssdk_back.sv =====
`timescale 1ns / 1ps

module ssdk_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_nonempty,
    input  ssdk_pkg::job_t    q_job,
    output logic              q_pop,
    output logic              result_valid,
    input  logic              result_stall,
    output ssdk_pkg::result_t result
);
    import ssdk_pkg::*;

    typedef enum logic [6:0] {
        ST_LOAD    = 7'b0000001,
        ST_SCAN    = 7'b0000010,
        ST_WAIT    = 7'b0000100,
        ST_SWAP_A  = 7'b0001000,
        ST_SWAP_B  = 7'b0010000,
        ST_EMIT_RD = 7'b0100000,
        ST_EMIT_WR = 7'b1000000
    } state_t;

    entry_t           mem [MAX_ENTRIES];
    entry_t           rd_data_reg;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] scan_reg;
    logic [IDX_W-1:0] scan_next;
    logic             rd_vld_reg;
    logic             rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             out_vld_reg;
    logic             out_vld_next;
    result_t          out_data_reg;

    entry_t           best_reg;
    logic [IDX_W-1:0] best_idx_reg;
    entry_t           head_ent_reg;

    logic             we;
    logic [IDX_W-1:0] wa;
    entry_t           wd;
    logic [CNT_W-1:0] cnt_m1;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] head_inc;
    logic             out_free;
    logic             out_load;

    assign cnt_m1       = count_reg - CNT_W'(1);
    assign last_idx     = cnt_m1[IDX_W-1:0];
    assign head_inc     = head_reg + IDX_W'(1);
    assign out_free     = !out_vld_reg || !result_stall;
    assign q_pop        = (state_reg == ST_LOAD) && q_nonempty;
    assign result_valid = out_vld_reg;
    assign result       = out_data_reg;

    // Sequencer: load the set, one selection pass per head position, then read out.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        head_next    = head_reg;
        scan_next    = scan_reg;
        rd_vld_next  = 1'b0;
        out_vld_next = out_vld_reg && result_stall;
        out_load     = 1'b0;
        we           = 1'b0;
        wa           = q_job.slot;
        wd.key       = q_job.item.key;
        wd.ident     = q_job.item.ident;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (q_nonempty)
                begin
                    we = q_job.store;
                    if (q_job.item.final_req)
                    begin
                        count_next = q_job.store ? CNT_W'(q_job.slot) + CNT_W'(1)
                                                 : CNT_W'(MAX_ENTRIES);
                        ovf_next   = q_job.ovf;
                        head_next  = '0;
                        scan_next  = '0;
                        state_next = (count_next == CNT_W'(1)) ? ST_EMIT_RD : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_vld_next = 1'b1;
                if (scan_reg == last_idx)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            ST_WAIT:
            begin
                state_next = ST_SWAP_A;
            end
            ST_SWAP_A:
            begin
                we         = 1'b1;
                wa         = best_idx_reg;
                wd         = head_ent_reg;
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B:
            begin
                we = 1'b1;
                wa = head_reg;
                wd = best_reg;
                if (head_inc == last_idx)
                begin
                    scan_next  = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    head_next  = head_inc;
                    scan_next  = head_inc;
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    out_vld_next = 1'b1;
                    if (scan_reg == last_idx)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        scan_next  = scan_reg + IDX_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            head_reg    <= '0;
            scan_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            head_reg    <= head_next;
            scan_reg    <= scan_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Sort store: one write port, one registered read port at the scan pointer.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[scan_reg];
    end

    // Running maximum of the pass; the head entry seeds it and is kept for the swap. Output word register.
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_reg;
        if (rd_vld_reg)
        begin
            if (rd_idx_reg == head_reg)
            begin
                head_ent_reg <= rd_data_reg;
                best_reg     <= rd_data_reg;
                best_idx_reg <= rd_idx_reg;
            end
            else if (rd_data_reg.key > best_reg.key)
            begin
                best_reg     <= rd_data_reg;
                best_idx_reg <= rd_idx_reg;
            end
        end
        if (out_load)
        begin
            out_data_reg.key_out   <= rd_data_reg.key;
            out_data_reg.ident_out <= rd_data_reg.ident;
            out_data_reg.run_end   <= (scan_reg == last_idx);
            out_data_reg.overflow  <= ovf_reg;
        end
    end

    // Outside loading, the set size stays within capacity and is never zero.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (count_reg >= CNT_W'(1))
                                   && (count_reg <= CNT_W'(MAX_ENTRIES)))
        else $error("set size out of range while sorting");

    // The selected entry lies in the unsorted part of the store.
    a_best_in_part: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWAP_A) |-> (best_idx_reg >= head_reg)
                                     && (best_idx_reg <= last_idx))
        else $error("selected index outside the unsorted part");

    // The swapped-in entry is never smaller than the head it replaces.
    a_best_is_max: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWAP_B) |-> (best_reg.key >= head_ent_reg.key))
        else $error("selected key below head key");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

import ssdk_pkg::*;

// Tracks the sorter: stores each accepted word, sorts a set when its final word
// arrives, and holds the sorted pairs that the block still owes.
class sort_tracker;
    logic [KEY_W-1:0]   keys [MAX_ENTRIES];
    logic [IDENT_W-1:0] idents [MAX_ENTRIES];
    int                 fill = 0;
    bit                 dropped = 1'b0;
    result_t            sorted_pairs [$];
    int                 errors = 0;

    // Notes one accepted input word and, on a final word, queues the sorted set.
    function void take_word(item_t w);
        int                 n;
        int                 head;
        int                 scan;
        int                 top;
        logic [KEY_W-1:0]   tk;
        logic [IDENT_W-1:0] ti;
        result_t            r;

        if (fill < MAX_ENTRIES)
        begin
            keys[fill] = w.key;
            idents[fill] = w.ident;
            fill++;
        end
        else
        begin
            dropped = 1'b1;
        end
        if (!w.final_req)
            return;

        // Selection sort, descending; the first strict maximum wins each pass.
        n = fill;
        for (head = 0; head + 1 < n; head++)
        begin
            top = head;
            for (scan = head + 1; scan < n; scan++)
                if (keys[scan] > keys[top])
                    top = scan;
            tk = keys[top];
            ti = idents[top];
            keys[top] = keys[head];
            idents[top] = idents[head];
            keys[head] = tk;
            idents[head] = ti;
        end
        for (int i = 0; i < n; i++)
        begin
            r.key_out = keys[i];
            r.ident_out = idents[i];
            r.run_end = (i + 1 == n);
            r.overflow = dropped;
            sorted_pairs.push_back(r);
        end
        fill = 0;
        dropped = 1'b0;
    endfunction

    // Compares one accepted output word with the oldest pending pair.
    function void check_pair(result_t got);
        result_t want;

        if (sorted_pairs.size() == 0)
        begin
            $display("%0t: unexpected word, expected none, actual key %h ident %h end %b ovf %b",
                     $time, got.key_out, got.ident_out, got.run_end, got.overflow);
            errors++;
            return;
        end
        want = sorted_pairs.pop_front();
        if (got.key_out !== want.key_out)
        begin
            $display("%0t: key_out mismatch, expected %h, actual %h",
                     $time, want.key_out, got.key_out);
            errors++;
        end
        if (got.ident_out !== want.ident_out)
        begin
            $display("%0t: ident_out mismatch, expected %h, actual %h",
                     $time, want.ident_out, got.ident_out);
            errors++;
        end
        if (got.run_end !== want.run_end)
        begin
            $display("%0t: run_end mismatch, expected %b, actual %b",
                     $time, want.run_end, got.run_end);
            errors++;
        end
        if (got.overflow !== want.overflow)
        begin
            $display("%0t: overflow mismatch, expected %b, actual %b",
                     $time, want.overflow, got.overflow);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int DIRECTED_WORDS = 24;
    localparam int RANDOM_WORDS   = 470;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 400;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_phase_e;
    typedef enum int {KEYS_SPREAD, KEYS_CLUSTERED, KEYS_EDGES} key_mix_e;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;

    sort_tracker tracker = new;
    int unsigned cycle_count = 0;
    int          send_gap_pct = 0;
    int          stall_pct = 0;
    int          words_sent = 0;

    selection_sort_descending_keyed_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Cycle counter and run limit.
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Output side stalls at random according to the current idle phase.
    always @(negedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Every accepted output word goes to the checker.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            tracker.check_pair(result);
    end

    // Offers one word, with random idle cycles first, and waits until it is taken.
    task automatic send_word(input item_t w);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        tracker.take_word(w);
        words_sent++;
        @(negedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(key_mix_e mix);
        case (mix)
            KEYS_CLUSTERED: return KEY_W'($urandom_range(0, 3));
            KEYS_EDGES:
            begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return '1;
                    default: return KEY_W'($urandom);
                endcase
            end
            default: return KEY_W'($urandom);
        endcase
    endfunction

    // Sends a set of the given size with random content; the last word is final.
    task automatic send_set(input int count, input key_mix_e mix);
        item_t w;

        for (int i = 0; i < count; i++)
        begin
            w.key = pick_key(mix);
            w.ident = IDENT_W'($urandom);
            w.final_req = (i == count - 1);
            send_word(w);
        end
    endtask

    task automatic set_idle_phase(input idle_phase_e phase);
        case (phase)
            IDLE_SENDER:   begin send_gap_pct = 54; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_gap_pct = 0;  stall_pct = 54; end
            IDLE_BOTH:     begin send_gap_pct = 25; stall_pct = 25; end
            default:       begin send_gap_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // Main sequence.
    initial
    begin
        item_t       w;
        int          phase;
        int          pick;
        int          count;
        logic [31:0] tie_keys [6];

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A set of one word at the top of both field ranges.
        set_idle_phase(IDLE_NONE);
        w.key = '1;
        w.ident = '1;
        w.final_req = 1'b1;
        send_word(w);

        // Extreme keys with ties, so the swap order of equal keys shows.
        tie_keys = '{32'd5, 32'd0, 32'hFFFF_FFFF, 32'd5, 32'd5, 32'd0};
        for (int i = 0; i < 6; i++)
        begin
            w.key = tie_keys[i];
            w.ident = (i == 1) ? 16'hFFFF : IDENT_W'(i);
            w.final_req = (i == 5);
            send_word(w);
        end

        // One word past capacity: the final word itself is dropped.
        for (int i = 0; i <= MAX_ENTRIES; i++)
        begin
            w.key = KEY_W'(i * 1000);
            w.ident = IDENT_W'(i);
            w.final_req = (i == MAX_ENTRIES);
            send_word(w);
        end

        // Random sets, mostly small, some full and some overflowing.
        while (words_sent < DIRECTED_WORDS + RANDOM_WORDS)
        begin
            phase = (words_sent - DIRECTED_WORDS) * 4 / RANDOM_WORDS;
            if (phase > 3)
                phase = 3;
            set_idle_phase(idle_phase_e'(phase));
            pick = $urandom_range(0, 99);
            if (pick < 70)
                count = $urandom_range(1, 6);
            else if (pick < 85)
                count = $urandom_range(7, MAX_ENTRIES - 1);
            else if (pick < 93)
                count = MAX_ENTRIES;
            else
                count = $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 4);
            send_set(count, key_mix_e'($urandom_range(0, 2)));
        end
        item_valid <= 1'b0;

        // Wait for every pending pair, then let the block settle.
        while (tracker.sorted_pairs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
